[hw/rtl/slri_pkg.sv]
// Shared types and constants for the sorted list insert/remove core.
`default_nettype none
package slri_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int DATA_W       = 32;
  localparam int STATUS_W     = 2;
  localparam int ECOUNT_W     = 5;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_MATCH = 2'd2;

  typedef struct packed {
    logic                     op;
    logic signed [DATA_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ECOUNT_W-1:0] entry_count;
    logic                empty_res;
  } result_t;

  // Broadcast from the sequencer to every cell.
  typedef struct packed {
    logic                     compare;
    logic                     apply;
    logic                     op;
    logic signed [DATA_W-1:0] value;
  } ctrl_t;

endpackage
`default_nettype wire

[hw/rtl/slri_cell.sv]
// One cell of the sorted list: holds an entry and trades it with its neighbors.
`default_nettype none
module slri_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  wire logic                             clk,
  input  wire slri_pkg::ctrl_t                  ctrl,
  input  wire logic [CNT_W-1:0]                 count,
  input  wire logic signed [slri_pkg::DATA_W-1:0] left_data,
  input  wire logic                             left_flag,
  input  wire logic signed [slri_pkg::DATA_W-1:0] right_data,
  output logic signed [slri_pkg::DATA_W-1:0]    data,
  output logic                                  flag,
  output logic                                  hit
);

  logic occ;
  logic eq;

  assign occ = count > CNT_W'(IDX);
  // First equal entry sits where the ge region starts.
  assign hit = eq && flag && !left_flag;

  always_ff @(posedge clk) begin
    if (ctrl.compare) begin
      // Insert: at or past the insertion point. Remove: at or past the first entry >= value.
      if (ctrl.op == slri_pkg::OP_REMOVE) begin
        flag <= occ && (data >= ctrl.value);
      end else begin
        flag <= !occ || (data > ctrl.value);
      end
      eq <= occ && (data == ctrl.value);
    end
    if (ctrl.apply && flag) begin
      if (ctrl.op == slri_pkg::OP_REMOVE) begin
        data <= right_data;
      end else if (left_flag) begin
        data <= left_data;
      end else begin
        data <= ctrl.value;
      end
    end
  end

endmodule
`default_nettype wire

[hw/rtl/sorted_list_insert_remove_core.sv]
// Top level of the sorted list insert/remove core: sequencer, count and cell chain.
// Holds up to CAPACITY signed 32-bit entries in ascending order in a row of cells.
// Each item inserts a value (after all entries <= it) or removes the first equal
// entry, and yields one result with status, entry count and empty flag. An item
// passes accept, a compare in every cell at once, then a shift by one position of
// the affected cells toward or away from the insertion/removal point; the apply
// step waits while a previous result is stalled, and is gated by the cells' match
// flag on a remove, by the full check on an insert. Reset clears state, count and
// result_valid; there is no clearing pass, entries past the count are never read.
`default_nettype none
module sorted_list_insert_remove_core #(
  parameter int CAPACITY = slri_pkg::CAPACITY_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_stall,
  input  wire slri_pkg::item_t   item,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output slri_pkg::result_t      result
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int DW    = slri_pkg::DATA_W;

  typedef enum logic [1:0] {S_IDLE, S_COMPARE, S_APPLY} state_t;

  state_t                state;
  logic                  op;
  logic signed [DW-1:0]  value;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  logic [slri_pkg::STATUS_W-1:0] status_next;
  logic [CNT_W+slri_pkg::ECOUNT_W-1:0] count_ext;
  logic                  out_free;
  logic                  full;
  logic                  found;
  logic                  do_apply;
  slri_pkg::ctrl_t       ctrl;

  logic signed [DW-1:0]  cell_data [CAPACITY];
  logic [CAPACITY-1:0]   cell_flag;
  logic [CAPACITY-1:0]   cell_hit;

  assign item_stall = (state != S_IDLE);
  assign out_free   = !result_valid || !result_stall;
  assign full       = (count == CNT_W'(CAPACITY));
  assign found      = |cell_hit;
  assign do_apply   = (state == S_APPLY) && out_free &&
                      ((op == slri_pkg::OP_REMOVE) ? found : !full);

  assign ctrl.compare = (state == S_COMPARE);
  assign ctrl.apply   = do_apply;
  assign ctrl.op      = op;
  assign ctrl.value   = value;

  always_comb begin
    count_next  = count;
    status_next = slri_pkg::ST_DONE;
    if (op == slri_pkg::OP_REMOVE) begin
      if (found) begin
        count_next = count - CNT_W'(1);
      end else begin
        status_next = slri_pkg::ST_NO_MATCH;
      end
    end else begin
      if (full) begin
        status_next = slri_pkg::ST_FULL;
      end else begin
        count_next = count + CNT_W'(1);
      end
    end
    count_ext = {{slri_pkg::ECOUNT_W{1'b0}}, count_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      // Drop a taken result; the apply step reloads the register itself.
      if (result_valid && !result_stall && (state != S_APPLY)) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            op    <= item.op;
            value <= item.value;
            state <= S_COMPARE;
          end
        end
        S_COMPARE: begin
          state <= S_APPLY;
        end
        S_APPLY: begin
          // Hold until the result register is free.
          if (out_free) begin
            count                <= count_next;
            result.status        <= status_next;
            result.entry_count   <= count_ext[slri_pkg::ECOUNT_W-1:0];
            result.empty_res     <= (count_next == '0);
            result_valid         <= 1'b1;
            state                <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DW-1:0] left_data;
    logic                 left_flag;
    logic signed [DW-1:0] right_data;

    if (i == 0) begin : g_first
      assign left_data = value;
      assign left_flag = 1'b0;
    end else begin : g_mid
      assign left_data = cell_data[i-1];
      assign left_flag = cell_flag[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_data = cell_data[i];
    end else begin : g_inner
      assign right_data = cell_data[i+1];
    end

    slri_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .count      (count),
      .left_data  (left_data),
      .left_flag  (left_flag),
      .right_data (right_data),
      .data       (cell_data[i]),
      .flag       (cell_flag[i]),
      .hit        (cell_hit[i])
    );
  end

endmodule
`default_nettype wire
